>>> sv/lags_pkg.sv
// Package with the types, constants and sizes shared by the grid step unit.
package lags_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 7;
    localparam int SWEEP_W    = ROW_W + 2;

    localparam logic [SIZE_W-1:0] WIDTH_MAX_C  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX_C = SIZE_W'(MAX_HEIGHT);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [3:0] SURVIVE_MIN = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] CROWD_LIMIT = 4'd4;

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [5:0]        cell_row;
        logic [5:0]        cell_col;
        logic              cell_value;
        logic [SIZE_W-1:0] region_left;
        logic [SIZE_W-1:0] region_top;
        logic [SIZE_W-1:0] region_right;
        logic [SIZE_W-1:0] region_bottom;
    } cmd_t;

    typedef struct packed {
        logic [1:0] done_operation;
        logic       read_value;
    } res_t;

endpackage

>>> sv/lags_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lags_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/lags_row_update.sv
// Next-generation computation of one row and merge inside the column range.
module lags_row_update
    import lags_pkg::*;
(
    input  row_t              row_above,
    input  row_t              row_mid,
    input  row_t              row_below,
    input  logic [SIZE_W-1:0] width_eff,
    input  logic [SIZE_W-1:0] col_first,
    input  logic [SIZE_W-1:0] col_end,
    output row_t              row_new
);

    row_t                 col_mask;
    row_t                 reg_mask;
    row_t                 life;
    logic [MAX_WIDTH+1:0] pad_a;
    logic [MAX_WIDTH+1:0] pad_m;
    logic [MAX_WIDTH+1:0] pad_b;
    logic [3:0]           cnt;

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            col_mask[i] = (SIZE_W'(i) < width_eff);
            reg_mask[i] = (SIZE_W'(i) >= col_first) && (SIZE_W'(i) < col_end);
        end
        pad_a = {1'b0, row_above & col_mask, 1'b0};
        pad_m = {1'b0, row_mid & col_mask, 1'b0};
        pad_b = {1'b0, row_below & col_mask, 1'b0};
        cnt   = '0;
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            cnt = 4'(pad_a[j]) + 4'(pad_a[j+1]) + 4'(pad_a[j+2])
                + 4'(pad_m[j]) + 4'(pad_m[j+2])
                + 4'(pad_b[j]) + 4'(pad_b[j+1]) + 4'(pad_b[j+2]);
            if (pad_m[j+1])
            begin
                life[j] = (cnt >= SURVIVE_MIN) && (cnt < CROWD_LIMIT);
            end
            else
            begin
                life[j] = (cnt == BIRTH_COUNT);
            end
        end
        row_new = (row_mid & ~reg_mask) | (life & reg_mask);
    end

endmodule

>>> sv/life_automaton_grid_step_unit.sv
// Top level of the Game of Life grid unit: control, row memory and sweep window.
// The grid lives in one row memory of MAX_HEIGHT rows by MAX_WIDTH cells.
// Commands arrive on the cmd channel (valid/ready); each transaction is a cell
// write, a cell read or a step of a rectangular region under rule B3/S23.
// Every command produces exactly one transaction on the res channel carrying
// the echoed operation code and, for a read, the cell value.
// Grid width and height are to be written on the cfg channel only while the unit
// is idle; the unit itself does not enforce this, and cfg_ready is always high.
// A cell read or write goes from acceptance to result through a memory read,
// a modify and write-back step and the load of the result into the output
// register. A step sweeps the rows of the region plus one row above and below
// through the single read port, one row per cycle, and writes each new row
// once the row below it has entered the window. An empty region or an unused
// operation code goes straight to the result. One command runs at a time.
// Reset clears per-row valid flags, so the whole grid reads as dead, and sets
// both size registers to 64. When the receiver stalls, the result stays in the
// output register; the next command may still be accepted and runs until its
// own result is ready, then waits for the output register to free up.
module life_automaton_grid_step_unit
    import lags_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CELL = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [SIZE_W-1:0]     grid_width_reg, grid_height_reg;
    logic [SIZE_W-1:0]     w_eff, h_eff;
    logic [MAX_HEIGHT-1:0] row_valid_reg;

    logic [1:0]            op_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  val_reg;
    logic                  cell_ok_reg;
    logic                  valid1_reg;
    logic                  rdval_reg;
    logic [ROW_W-1:0]      ram_raddr_hold;

    logic [SIZE_W-1:0]     x0_reg, x1_reg, y0_reg, y1_reg;
    logic [SIZE_W-1:0]     x0_c, x1_c, y0_c, y1_c;
    logic [SWEEP_W-1:0]    rd_row_reg;
    logic                  issuing_reg;
    logic                  p1_vld_reg;
    logic [SWEEP_W-1:0]    p1_row_reg;
    logic                  p1_valid_reg;
    row_t                  prev_reg, cur_reg, nxt_reg;
    logic                  win_vld_reg;
    logic [SWEEP_W-1:0]    win_row_reg;

    logic                  res_valid_reg;
    res_t                  res_reg;

    logic                  accept;
    logic                  ram_re, ram_we;
    logic [ROW_W-1:0]      ram_raddr, ram_waddr;
    row_t                  ram_rdata, ram_wdata;
    row_t                  cell_row_data, cell_row_new;
    row_t                  step_row_new;
    logic                  step_write, step_last;
    logic                  out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || res_ready;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = SIZE_W'(1);
        end
        else if (grid_width_reg > WIDTH_MAX_C)
        begin
            w_eff = WIDTH_MAX_C;
        end
        else
        begin
            w_eff = grid_width_reg;
        end
        if (grid_height_reg == '0)
        begin
            h_eff = SIZE_W'(1);
        end
        else if (grid_height_reg > HEIGHT_MAX_C)
        begin
            h_eff = HEIGHT_MAX_C;
        end
        else
        begin
            h_eff = grid_height_reg;
        end
        x0_c = (cmd.region_left   > w_eff) ? w_eff : cmd.region_left;
        x1_c = (cmd.region_right  > w_eff) ? w_eff : cmd.region_right;
        y0_c = (cmd.region_top    > h_eff) ? h_eff : cmd.region_top;
        y1_c = (cmd.region_bottom > h_eff) ? h_eff : cmd.region_bottom;
    end

    // Cell read-modify-write path.
    always_comb
    begin
        cell_row_data          = valid1_reg ? ram_rdata : '0;
        cell_row_new           = cell_row_data;
        cell_row_new[col_reg]  = val_reg;
    end

    lags_row_update u_row_update (
        .row_above (prev_reg),
        .row_mid   (cur_reg),
        .row_below (nxt_reg),
        .width_eff (w_eff),
        .col_first (x0_reg),
        .col_end   (x1_reg),
        .row_new   (step_row_new)
    );

    assign step_write = (state_reg == ST_STEP) && win_vld_reg
                        && (win_row_reg >= (SWEEP_W'(y0_reg) + SWEEP_W'(1)))
                        && (win_row_reg <= SWEEP_W'(y1_reg));
    assign step_last  = (state_reg == ST_STEP) && win_vld_reg
                        && (win_row_reg == SWEEP_W'(y1_reg));

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = cmd.cell_row[ROW_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = cmd.cell_row[ROW_W-1:0];
        ram_wdata = cell_row_new;
        case (state_reg)
            ST_IDLE:
            begin
                ram_re    = accept && ((cmd.operation == OP_WRITE)
                                       || (cmd.operation == OP_READ));
                ram_raddr = cmd.cell_row[ROW_W-1:0];
            end
            ST_CELL:
            begin
                ram_we    = (op_reg == OP_WRITE) && cell_ok_reg;
                ram_waddr = ram_raddr_hold;
                ram_wdata = cell_row_new;
            end
            ST_STEP:
            begin
                ram_re    = issuing_reg;
                ram_raddr = rd_row_reg[ROW_W-1:0];
                ram_we    = step_write;
                ram_waddr = ROW_W'(win_row_reg - SWEEP_W'(1));
                ram_wdata = step_row_new;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    lags_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.operation == OP_WRITE) || (cmd.operation == OP_READ))
                    begin
                        state_next = ST_CELL;
                    end
                    else if ((cmd.operation == OP_STEP) && (x0_c < x1_c) && (y0_c < y1_c))
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CELL:
            begin
                state_next = ST_DONE;
            end
            ST_STEP:
            begin
                if (step_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            grid_width_reg  <= WIDTH_MAX_C;
            grid_height_reg <= HEIGHT_MAX_C;
            row_valid_reg   <= '0;
            res_valid_reg   <= 1'b0;
            issuing_reg     <= 1'b0;
            p1_vld_reg      <= 1'b0;
            win_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_GRID_WIDTH)
                begin
                    grid_width_reg <= cfg_data;
                end
                else if (cfg_index == CFG_GRID_HEIGHT)
                begin
                    grid_height_reg <= cfg_data;
                end
            end
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                issuing_reg <= 1'b1;
            end
            else if (issuing_reg && (rd_row_reg == SWEEP_W'(y1_reg)))
            begin
                issuing_reg <= 1'b0;
            end
            p1_vld_reg  <= (state_reg == ST_STEP) && issuing_reg;
            win_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= cmd.operation;
            col_reg        <= cmd.cell_col[COL_W-1:0];
            val_reg        <= cmd.cell_value;
            ram_raddr_hold <= cmd.cell_row[ROW_W-1:0];
            cell_ok_reg    <= (SIZE_W'(cmd.cell_row) < h_eff)
                              && (SIZE_W'(cmd.cell_col) < w_eff);
            valid1_reg     <= row_valid_reg[cmd.cell_row[ROW_W-1:0]];
            x0_reg         <= x0_c;
            x1_reg         <= x1_c;
            y0_reg         <= y0_c;
            y1_reg         <= y1_c;
            rd_row_reg     <= SWEEP_W'(y0_c) - SWEEP_W'(1);
            rdval_reg      <= 1'b0;
        end
        else if (state_reg == ST_CELL)
        begin
            rdval_reg <= (op_reg == OP_READ) && cell_ok_reg && cell_row_data[col_reg];
        end
        if ((state_reg == ST_STEP) && issuing_reg)
        begin
            rd_row_reg   <= rd_row_reg + SWEEP_W'(1);
            p1_row_reg   <= rd_row_reg;
            p1_valid_reg <= row_valid_reg[rd_row_reg[ROW_W-1:0]];
        end
        if (p1_vld_reg)
        begin
            prev_reg    <= cur_reg;
            cur_reg     <= nxt_reg;
            nxt_reg     <= ((p1_row_reg < SWEEP_W'(h_eff)) && p1_valid_reg) ? ram_rdata : '0;
            win_row_reg <= p1_row_reg;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            res_reg.done_operation <= op_reg;
            res_reg.read_value     <= rdval_reg;
        end
    end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the Game of Life grid step unit with a cell-grid predictor.
`timescale 1ns / 1ps

module testbench
    import lags_pkg::*;
();

    localparam int CLK_PERIOD        = 4;
    localparam int RESET_CYCLES      = 3;
    localparam int CYCLE_LIMIT       = 1000000;
    localparam int END_SETTLE_CYCLES = 80;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int LIVE_MIN   = 2;
    localparam int LIVE_BIRTH = 3;
    localparam int LIVE_CROWD = 4;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    cmd_t              cmd       = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_t              res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [SIZE_W-1:0] cfg_data  = '0;

    logic [MAX_WIDTH-1:0] life_grid [MAX_HEIGHT];
    logic [SIZE_W-1:0]    grid_cols_cfg = WIDTH_MAX_C;
    logic [SIZE_W-1:0]    grid_rows_cfg = HEIGHT_MAX_C;
    res_t                 expected_results [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int size_settings  = 0;
    int cycle_count    = 0;
    int op_count [4];

    life_automaton_grid_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int effective_size(input logic [SIZE_W-1:0] reg_value, input int max_size);
        if (reg_value == 0)
        begin
            return 1;
        end
        if (int'(reg_value) > max_size)
        begin
            return max_size;
        end
        return int'(reg_value);
    endfunction

    function automatic res_t apply_life_command(input cmd_t c);
        res_t                 r;
        int                   w, h, x0, y0, x1, y1, alive, rr, cc;
        logic [MAX_WIDTH-1:0] prior [MAX_HEIGHT];
        r = '0;
        r.done_operation = c.operation;
        w = effective_size(grid_cols_cfg, MAX_WIDTH);
        h = effective_size(grid_rows_cfg, MAX_HEIGHT);
        case (c.operation)
            OP_WRITE:
            begin
                if (int'(c.cell_row) < h && int'(c.cell_col) < w)
                begin
                    life_grid[c.cell_row][c.cell_col] = c.cell_value;
                end
            end
            OP_READ:
            begin
                if (int'(c.cell_row) < h && int'(c.cell_col) < w)
                begin
                    r.read_value = life_grid[c.cell_row][c.cell_col];
                end
            end
            OP_STEP:
            begin
                prior = life_grid;
                x0 = (int'(c.region_left) > w) ? w : int'(c.region_left);
                y0 = (int'(c.region_top) > h) ? h : int'(c.region_top);
                x1 = (int'(c.region_right) > w) ? w : int'(c.region_right);
                y1 = (int'(c.region_bottom) > h) ? h : int'(c.region_bottom);
                for (int i = y0; i < y1; i++)
                begin
                    for (int j = x0; j < x1; j++)
                    begin
                        alive = 0;
                        for (int di = -1; di <= 1; di++)
                        begin
                            for (int dj = -1; dj <= 1; dj++)
                            begin
                                rr = i + di;
                                cc = j + dj;
                                if ((di != 0 || dj != 0) && rr >= 0 && rr < h && cc >= 0
                                    && cc < w && prior[rr][cc])
                                begin
                                    alive++;
                                end
                            end
                        end
                        if (prior[i][j])
                        begin
                            life_grid[i][j] = (alive >= LIVE_MIN && alive < LIVE_CROWD);
                        end
                        else
                        begin
                            life_grid[i][j] = (alive == LIVE_BIRTH);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t cell_command(input logic [1:0] op, input int row, input int col,
                                          input logic value);
        cmd_t c;
        c = '0;
        c.operation  = op;
        c.cell_row   = 6'(row);
        c.cell_col   = 6'(col);
        c.cell_value = value;
        return c;
    endfunction

    function automatic cmd_t region_command(input int left, input int top, input int right,
                                            input int bottom);
        cmd_t c;
        c = '0;
        c.operation     = OP_STEP;
        c.region_left   = SIZE_W'(left);
        c.region_top    = SIZE_W'(top);
        c.region_right  = SIZE_W'(right);
        c.region_bottom = SIZE_W'(bottom);
        return c;
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        int   w, h, pick, lo;
        w = effective_size(grid_cols_cfg, MAX_WIDTH);
        h = effective_size(grid_rows_cfg, MAX_HEIGHT);
        c = $bits(cmd_t)'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            c.operation = OP_WRITE;
        end
        else if (pick < 75)
        begin
            c.operation = OP_READ;
        end
        else if (pick < 96)
        begin
            c.operation = OP_STEP;
        end
        else
        begin
            c.operation = OP_UNUSED;
        end
        if ($urandom_range(9) < 8)
        begin
            c.cell_row = 6'($urandom_range(h - 1));
            c.cell_col = 6'($urandom_range(w - 1));
        end
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            lo = $urandom_range(w - 1);
            c.region_left  = SIZE_W'(lo);
            c.region_right = SIZE_W'($urandom_range(w, lo + 1));
            lo = $urandom_range(h - 1);
            c.region_top    = SIZE_W'(lo);
            c.region_bottom = SIZE_W'($urandom_range(h, lo + 1));
        end
        else if (pick < 8)
        begin
            c.region_left   = '0;
            c.region_top    = '0;
            c.region_right  = SIZE_W'($urandom_range(127, w));
            c.region_bottom = SIZE_W'($urandom_range(127, h));
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_command(input cmd_t c);
        res_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        predicted = apply_life_command(c);
        expected_results.insert(expected_results.size(), predicted);
        op_count[c.operation]++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (expected_results.size() != 0);
    endtask

    task automatic write_registers(input logic [1:0] idx_a, input logic [SIZE_W-1:0] data_a,
                                   input logic [1:0] idx_b, input logic [SIZE_W-1:0] data_b);
        logic [1:0]        idx [2];
        logic [SIZE_W-1:0] data [2];
        idx[0]  = idx_a;
        idx[1]  = idx_b;
        data[0] = data_a;
        data[1] = data_b;
        for (int k = 0; k < 2; k++)
        begin
            if (k > 0)
            begin
                @(negedge clk);
            end
            cfg_index <= idx[k];
            cfg_data  <= data[k];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (idx[k])
                CFG_GRID_WIDTH:  grid_cols_cfg = data[k];
                CFG_GRID_HEIGHT: grid_rows_cfg = data[k];
                default:
                begin
                end
            endcase
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid_size(input logic [SIZE_W-1:0] cols, input logic [SIZE_W-1:0] rows);
        drain_results();
        write_registers(CFG_GRID_WIDTH, cols, CFG_GRID_HEIGHT, rows);
        size_settings++;
    endtask

    task automatic test_basic_operations();
        send_command(cell_command(OP_WRITE, 0, 0, 1'b1));
        send_command(cell_command(OP_WRITE, 63, 63, 1'b1));
        send_command(cell_command(OP_WRITE, 0, 63, 1'b1));
        send_command(cell_command(OP_WRITE, 63, 0, 1'b1));
        send_command(cell_command(OP_READ, 0, 0, 1'b0));
        send_command(cell_command(OP_READ, 63, 63, 1'b0));
        send_command(cell_command(OP_READ, 0, 63, 1'b0));
        send_command(cell_command(OP_READ, 63, 0, 1'b0));
        send_command(cell_command(OP_READ, 5, 5, 1'b0));
        send_command(cell_command(OP_WRITE, 10, 9, 1'b1));
        send_command(cell_command(OP_WRITE, 10, 10, 1'b1));
        send_command(cell_command(OP_WRITE, 10, 11, 1'b1));
        send_command(region_command(0, 0, 127, 127));
        send_command(cell_command(OP_READ, 9, 10, 1'b0));
        send_command(cell_command(OP_READ, 11, 10, 1'b0));
        send_command(cell_command(OP_READ, 10, 9, 1'b0));
        send_command(region_command(20, 0, 20, 64));
        send_command(region_command(40, 5, 10, 20));
        send_command(cell_command(OP_UNUSED, 63, 63, 1'b1));
        send_command(cell_command(OP_WRITE, 10, 10, 1'b0));
        send_command(cell_command(OP_READ, 10, 10, 1'b0));
    endtask

    task automatic test_size_extremes();
        logic [SIZE_W-1:0] cols [6] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd127, 7'd64};
        logic [SIZE_W-1:0] rows [6] = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd3, 7'd64};
        drain_results();
        write_registers(CFG_SPARE_2, SIZE_W'($urandom), CFG_SPARE_3, SIZE_W'($urandom));
        for (int k = 0; k < 6; k++)
        begin
            set_grid_size(cols[k], rows[k]);
            repeat (30)
            begin
                send_command(random_command());
            end
        end
    endtask

    task automatic test_random_grids(input int n_sizes, input int per_size);
        logic [SIZE_W-1:0] cols, rows;
        repeat (n_sizes)
        begin
            cols = ($urandom_range(4) != 0) ? SIZE_W'($urandom_range(16, 3))
                                            : SIZE_W'($urandom_range(127));
            rows = ($urandom_range(4) != 0) ? SIZE_W'($urandom_range(16, 3))
                                            : SIZE_W'($urandom_range(127));
            set_grid_size(cols, rows);
            repeat (per_size)
            begin
                send_command(random_command());
            end
        end
    endtask

    task automatic test_drain_pause();
        set_grid_size(7'd8, 7'd8);
        repeat (4)
        begin
            repeat (5)
            begin
                send_command(random_command());
            end
            drain_results();
        end
    endtask

    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result transaction with no command outstanding (op %0d)",
                                          res.done_operation));
            end
            else
            begin
                want = expected_results.pop_front();
                if (res.done_operation !== want.done_operation)
                begin
                    report_mismatch($sformatf("done_operation %0d, expected %0d",
                                              res.done_operation, want.done_operation));
                end
                if (res.read_value !== want.read_value)
                begin
                    report_mismatch($sformatf("read_value %0b, expected %0b for op %0d",
                                              res.read_value, want.read_value,
                                              want.done_operation));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: cycle limit of %0d reached with %0d results outstanding",
                     CYCLE_LIMIT, expected_results.size());
            $display("life_automaton_grid_step_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        foreach (life_grid[i])
        begin
            life_grid[i] = '0;
        end
        foreach (op_count[i])
        begin
            op_count[i] = 0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 74;
        test_basic_operations();
        test_size_extremes();

        send_idle_pct = 74;
        recv_idle_pct = 36;
        test_random_grids(8, 40);
        test_drain_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_grids(8, 40);

        drain_results();
        repeat (END_SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d writes, %0d reads, %0d steps and %0d unused-code commands",
                 op_count[OP_WRITE], op_count[OP_READ], op_count[OP_STEP], op_count[OP_UNUSED]);
        $display("across %0d grid sizes; %0d results checked, %0d mismatches",
                 size_settings, results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("life_automaton_grid_step_unit verification clean");
        end
        else
        begin
            $display("life_automaton_grid_step_unit verification failed");
        end
        $finish;
    end

endmodule
